>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SSPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SSPG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/sspg_pkg.sv
`timescale 1ns / 1ps

package sspg_pkg;

  localparam int POS_W      = 24;
  localparam int AXIS_W     = 16;
  localparam int VOL_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = DIFF_W + AXIS_W;
  localparam int PROJ_W     = PROD_W + 1;
  localparam int SQR_W      = 2 * POS_W;
  localparam int SQ_W       = 50;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int MAG_W      = PROJ_W + 1;
  localparam int DIV_N_W    = MAG_W;
  localparam int DIV_D_W    = ROOT_W + 1;
  localparam int DIV_Q_W    = 16;
  localparam int DIV_R_W    = DIV_D_W + 1;
  localparam int SIDE_W     = 64;
  localparam int HALF_W     = 16;
  localparam int T_W        = 17;
  localparam int RAD2_W     = T_W + 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIV_D_W-1:0] ONE_Q12   = DIV_D_W'(4096);
  localparam logic [DIV_D_W-1:0] TENTH_DEN = DIV_D_W'(40960);
  localparam logic [T_W-1:0]     COS_ONE   = T_W'(32768);
  localparam logic [SQ_W-1:0]    HALF_SQ   = SQ_W'(64'd1 << 30);
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LISTENER_X = 8'd0,
    REG_LISTENER_Y = 8'd1,
    REG_LISTENER_Z = 8'd2,
    REG_AXIS_X     = 8'd3,
    REG_AXIS_Y     = 8'd4,
    REG_AXIS_Z     = 8'd5
  } reg_index_t;

  localparam logic signed [AXIS_W-1:0] AXIS_X_RESET = AXIS_W'(16384);

endpackage

>>> design/sspg_front.sv
`timescale 1ns / 1ps

module sspg_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [sspg_pkg::POS_W-1:0]     sx,
  input  logic signed [sspg_pkg::POS_W-1:0]     sy,
  input  logic signed [sspg_pkg::POS_W-1:0]     sz,
  input  logic signed [sspg_pkg::POS_W-1:0]     lx,
  input  logic signed [sspg_pkg::POS_W-1:0]     ly,
  input  logic signed [sspg_pkg::POS_W-1:0]     lz,
  input  logic signed [sspg_pkg::AXIS_W-1:0]    ax,
  input  logic signed [sspg_pkg::AXIS_W-1:0]    ay,
  input  logic signed [sspg_pkg::AXIS_W-1:0]    az,
  input  logic [sspg_pkg::VOL_W-1:0]            vol,
  input  logic                                  pos,
  output logic                                  out_valid,
  output logic [sspg_pkg::SQ_W-1:0]             sq,
  output logic [sspg_pkg::MAG_W-1:0]            mag,
  output logic                                  neg,
  output logic [sspg_pkg::VOL_W-1:0]            out_vol,
  output logic                                  out_pos
);

  // stage 1: offsets
  logic                                 v1;
  logic signed [sspg_pkg::DIFF_W-1:0]   d1 [3];
  logic [sspg_pkg::VOL_W-1:0]           vol1;
  logic                                 pos1;
  // stage 2: products and squares
  logic                                 v2;
  logic signed [sspg_pkg::PROD_W-1:0]   p2 [3];
  logic [sspg_pkg::SQR_W-1:0]           s2 [3];
  logic [sspg_pkg::VOL_W-1:0]           vol2;
  logic                                 pos2;

  logic signed [sspg_pkg::AXIS_W-1:0]   axis [3];
  logic [sspg_pkg::POS_W-1:0]           ad [3];
  logic signed [sspg_pkg::PROJ_W-1:0]   proj;
  logic [sspg_pkg::PROJ_W-1:0]          absp;

  assign axis[0] = ax;
  assign axis[1] = ay;
  assign axis[2] = az;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ad[i] = d1[i][sspg_pkg::DIFF_W-1] ? sspg_pkg::POS_W'(-d1[i])
                                         : sspg_pkg::POS_W'(d1[i]);
    end
    proj = sspg_pkg::PROJ_W'(p2[0]) + sspg_pkg::PROJ_W'(p2[1]) + sspg_pkg::PROJ_W'(p2[2]);
    absp = proj[sspg_pkg::PROJ_W-1] ? sspg_pkg::PROJ_W'(-proj) : sspg_pkg::PROJ_W'(proj);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= sspg_pkg::DIFF_W'(sx) - sspg_pkg::DIFF_W'(lx);
      d1[1] <= sspg_pkg::DIFF_W'(sy) - sspg_pkg::DIFF_W'(ly);
      d1[2] <= sspg_pkg::DIFF_W'(sz) - sspg_pkg::DIFF_W'(lz);
      vol1 <= vol;
      pos1 <= pos;
      for (int i = 0; i < 3; i++) begin
        p2[i] <= d1[i] * axis[i];
        s2[i] <= ad[i] * ad[i];
      end
      vol2 <= vol1;
      pos2 <= pos1;
      sq <= sspg_pkg::SQ_W'(s2[0]) + sspg_pkg::SQ_W'(s2[1]) + sspg_pkg::SQ_W'(s2[2]);
      mag <= {absp, 1'b0};
      neg <= proj[sspg_pkg::PROJ_W-1];
      out_vol <= vol2;
      out_pos <= pos2;
    end
  end

endmodule

>>> design/sspg_isqrt.sv
`timescale 1ns / 1ps

module sspg_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [sspg_pkg::SQ_W-1:0]      rad,
  input  logic [sspg_pkg::SIDE_W-1:0]    in_side,
  output logic                           out_valid,
  output logic [sspg_pkg::ROOT_W-1:0]    root,
  output logic [sspg_pkg::SIDE_W-1:0]    out_side
);

  localparam int ITER = sspg_pkg::ROOT_W;

  logic                          v   [ITER+1];
  logic [sspg_pkg::SQ_W-1:0]     x   [ITER+1];
  logic [sspg_pkg::REM_W-1:0]    rem [ITER+1];
  logic [sspg_pkg::ROOT_W-1:0]   rt  [ITER+1];
  logic [sspg_pkg::SIDE_W-1:0]   sd  [ITER+1];

  assign v[0]   = in_valid;
  assign x[0]   = rad;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  // one result bit per stage: bring down two radicand bits, try 4r+1
  for (genvar k = 0; k < ITER; k++) begin : g_step
    logic [sspg_pkg::REM_W-1:0] rem_sh;
    logic [sspg_pkg::REM_W-1:0] trial;
    logic                       take;

    always_comb begin
      rem_sh = {rem[k][sspg_pkg::REM_W-3:0], x[k][sspg_pkg::SQ_W-1 -: 2]};
      trial  = sspg_pkg::REM_W'({rt[k], 2'b01});
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x[k+1]   <= {x[k][sspg_pkg::SQ_W-3:0], 2'b00};
        rem[k+1] <= take ? rem_sh - trial : rem_sh;
        rt[k+1]  <= {rt[k][sspg_pkg::ROOT_W-2:0], take};
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = v[ITER];
  assign root      = rt[ITER];
  assign out_side  = sd[ITER];

endmodule

>>> design/sspg_div.sv
`timescale 1ns / 1ps

module sspg_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  logic [sspg_pkg::DIV_N_W-1:0]    num,
  input  logic [sspg_pkg::DIV_D_W-1:0]    den,
  input  logic [sspg_pkg::SIDE_W-1:0]     in_side,
  output logic                            out_valid,
  output logic                            sat,
  output logic [sspg_pkg::DIV_Q_W-1:0]    quot,
  output logic [sspg_pkg::SIDE_W-1:0]     out_side
);

  localparam int QW   = sspg_pkg::DIV_Q_W;
  localparam int RW   = sspg_pkg::DIV_R_W;
  localparam int HI_W = sspg_pkg::DIV_N_W - QW;

  logic                          v   [QW+1];
  logic                          st  [QW+1];
  logic [RW-1:0]                 rem [QW+1];
  logic [QW-1:0]                 lo  [QW+1];
  logic [QW-1:0]                 q   [QW+1];
  logic [sspg_pkg::DIV_D_W-1:0]  dv  [QW+1];
  logic [sspg_pkg::SIDE_W-1:0]   sd  [QW+1];

  // quotient of 2^QW or more saturates; otherwise the upper part is below den
  assign v[0]   = in_valid;
  assign st[0]  = num >= sspg_pkg::DIV_N_W'({den, {QW{1'b0}}});
  assign rem[0] = RW'(num[sspg_pkg::DIV_N_W-1 -: HI_W]);
  assign lo[0]  = num[QW-1:0];
  assign q[0]   = '0;
  assign dv[0]  = den;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW:0] rem_sh;
    logic        take;

    always_comb begin
      rem_sh = {rem[k], lo[k][QW-1]};
      take   = rem_sh >= (RW+1)'(dv[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= take ? RW'(rem_sh - (RW+1)'(dv[k])) : RW'(rem_sh);
        lo[k+1]  <= {lo[k][QW-2:0], 1'b0};
        q[k+1]   <= {q[k][QW-2:0], take};
        st[k+1]  <= st[k];
        dv[k+1]  <= dv[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = v[QW];
  assign sat       = st[QW];
  assign quot      = q[QW];
  assign out_side  = sd[QW];

endmodule

>>> design/spatial_stereo_pan_gain_unit.sv
`timescale 1ns / 1ps
// Stereo pan gain unit: left/right gains for one sound source per request.
// Source channel (src_valid / src_stall): source_x/y/z (Q12.12), base_volume
// (Q1.15) and is_positional. Result channel (res_valid / res_stall):
// left_gain and right_gain, unsigned Q1.15, saturated.
// Config channel (cfg_valid / cfg_ready): cfg_index selects listener x, y, z
// (0..2, Q12.12) or right axis x, y, z (3..5, Q2.14, low 16 bits of cfg_data).
// Other indexes are ignored. cfg_ready is always high. Write only while idle.
// Throughput: one request per cycle unless res_stall holds the pipeline. The
// chain runs through the front end, distance square root, cosine divider,
// half-angle sine root, cosine root, gain dividers and four glue/output
// registers.
// Every stage advances together: when res_valid is high and res_stall is
// high the whole pipeline holds, src_stall rises, and nothing is lost.
// Reset clears every valid bit and loads the listener at the origin with
// a right axis of +x. Non-positional requests ride the same pipeline and
// return base_volume on both channels.

`include "assert_macros.svh"

module spatial_stereo_pan_gain_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sspg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sspg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   src_valid,
  output logic                                   src_stall,
  input  logic signed [sspg_pkg::POS_W-1:0]      source_x,
  input  logic signed [sspg_pkg::POS_W-1:0]      source_y,
  input  logic signed [sspg_pkg::POS_W-1:0]      source_z,
  input  logic [sspg_pkg::VOL_W-1:0]             base_volume,
  input  logic                                   is_positional,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic [sspg_pkg::GAIN_W-1:0]            left_gain,
  output logic [sspg_pkg::GAIN_W-1:0]            right_gain
);

  localparam int SW = sspg_pkg::SIDE_W;
  localparam int VW = sspg_pkg::VOL_W;
  localparam int RW = sspg_pkg::ROOT_W;
  localparam int MW = sspg_pkg::MAG_W;
  localparam int HW = sspg_pkg::HALF_W;

  // listener registers
  logic signed [sspg_pkg::POS_W-1:0]  lis_x, lis_y, lis_z;
  logic signed [sspg_pkg::AXIS_W-1:0] axis_x, axis_y, axis_z;

  // whole pipeline moves when the output register is free or being drained
  logic adv;
  assign adv       = !res_valid || !res_stall;
  assign src_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lis_x  <= '0;
      lis_y  <= '0;
      lis_z  <= '0;
      axis_x <= sspg_pkg::AXIS_X_RESET;
      axis_y <= '0;
      axis_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sspg_pkg::REG_LISTENER_X: lis_x  <= cfg_data;
        sspg_pkg::REG_LISTENER_Y: lis_y  <= cfg_data;
        sspg_pkg::REG_LISTENER_Z: lis_z  <= cfg_data;
        sspg_pkg::REG_AXIS_X:     axis_x <= cfg_data[sspg_pkg::AXIS_W-1:0];
        sspg_pkg::REG_AXIS_Y:     axis_y <= cfg_data[sspg_pkg::AXIS_W-1:0];
        sspg_pkg::REG_AXIS_Z:     axis_z <= cfg_data[sspg_pkg::AXIS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front end: offset, projection on the right axis, squared distance
  logic                        f_valid;
  logic [sspg_pkg::SQ_W-1:0]   f_sq;
  logic [MW-1:0]               f_mag;
  logic                        f_neg;
  logic [VW-1:0]               f_vol;
  logic                        f_pos;

  sspg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (src_valid && !src_stall),
    .sx        (source_x),
    .sy        (source_y),
    .sz        (source_z),
    .lx        (lis_x),
    .ly        (lis_y),
    .lz        (lis_z),
    .ax        (axis_x),
    .ay        (axis_y),
    .az        (axis_z),
    .vol       (base_volume),
    .pos       (is_positional),
    .out_valid (f_valid),
    .sq        (f_sq),
    .mag       (f_mag),
    .neg       (f_neg),
    .out_vol   (f_vol),
    .out_pos   (f_pos)
  );

  // distance = floor(sqrt(sum of squares)), Q.12
  logic           r1_valid;
  logic [RW-1:0]  r1_root;
  logic [SW-1:0]  r1_side;

  sspg_isqrt u_dist_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .rad       (f_sq),
    .in_side   (SW'({f_mag, f_neg, f_vol, f_pos})),
    .out_valid (r1_valid),
    .root      (r1_root),
    .out_side  (r1_side)
  );

  // cosine magnitude = 2|proj| / (dist + 1.0)
  logic                            d1_valid, d1_sat;
  logic [sspg_pkg::DIV_Q_W-1:0]    d1_quot;
  logic [SW-1:0]                   d1_side;

  sspg_div u_cos_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (r1_valid),
    .num       (r1_side[VW+2 +: MW]),
    .den       (sspg_pkg::DIV_D_W'(r1_root) + sspg_pkg::ONE_Q12),
    .in_side   (SW'({r1_root, r1_side[VW+1], r1_side[VW:0]})),
    .out_valid (d1_valid),
    .sat       (d1_sat),
    .quot      (d1_quot),
    .out_side  (d1_side)
  );

  // clamp cosine to one, form (1 - cos) * 2^14 for the half-angle sine
  logic                        c_valid;
  logic [sspg_pkg::RAD2_W-1:0] c_rad;
  logic [RW-1:0]               c_dist;
  logic [VW:0]                 c_volpos;
  logic [sspg_pkg::T_W-1:0]    cq, ct;

  always_comb begin
    cq = (d1_sat || sspg_pkg::T_W'(d1_quot) > sspg_pkg::COS_ONE)
         ? sspg_pkg::COS_ONE : sspg_pkg::T_W'(d1_quot);
    ct = d1_side[VW+1] ? sspg_pkg::COS_ONE + cq : sspg_pkg::COS_ONE - cq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_rad    <= {ct, 14'd0};
      c_dist   <= d1_side[VW+2 +: RW];
      c_volpos <= d1_side[VW:0];
    end
  end

  // half-angle sine
  logic           r2_valid;
  logic [RW-1:0]  r2_root;
  logic [SW-1:0]  r2_side;

  sspg_isqrt u_sin_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c_valid),
    .rad       (sspg_pkg::SQ_W'(c_rad)),
    .in_side   (SW'({c_dist, c_volpos})),
    .out_valid (r2_valid),
    .root      (r2_root),
    .out_side  (r2_side)
  );

  // square the sine for the cosine root
  logic              e_valid;
  logic [2*HW-1:0]   e_sq;
  logic [HW-1:0]     e_sh;
  logic [RW-1:0]     e_dist;
  logic [VW:0]       e_volpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sq     <= r2_root[HW-1:0] * r2_root[HW-1:0];
      e_sh     <= r2_root[HW-1:0];
      e_dist   <= r2_side[VW+1 +: RW];
      e_volpos <= r2_side[VW:0];
    end
  end

  // half-angle cosine = sqrt(1 - sin^2)
  logic           r3_valid;
  logic [RW-1:0]  r3_root;
  logic [SW-1:0]  r3_side;

  sspg_isqrt u_cos_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (e_valid),
    .rad       (sspg_pkg::HALF_SQ - sspg_pkg::SQ_W'(e_sq)),
    .in_side   (SW'({e_sh, e_dist, e_volpos})),
    .out_valid (r3_valid),
    .root      (r3_root),
    .out_side  (r3_side)
  );

  // scale each half-angle term by the volume; distance falloff divisor
  logic                          g_valid;
  logic [2*HW-1:0]               g_left, g_right;
  logic [sspg_pkg::DIV_D_W-1:0]  g_den;
  logic [VW:0]                   g_volpos;
  logic [HW-1:0]                 r3_sh;

  assign r3_sh = r3_side[VW+1+RW +: HW];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= r3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_left   <= r3_sh * r3_side[VW:1];
      g_right  <= r3_root[HW-1:0] * r3_side[VW:1];
      g_den    <= sspg_pkg::TENTH_DEN + sspg_pkg::DIV_D_W'(r3_side[VW+1 +: RW]);
      g_volpos <= r3_side[VW:0];
    end
  end

  // gain = floor(h * vol * 1.25 / (40960 + dist)); 1.25 = 40960 / 2^15
  logic [sspg_pkg::DIV_N_W-1:0] n_left, n_right;
  assign n_left  = sspg_pkg::DIV_N_W'(({g_left, 2'b00} + (2*HW+2)'(g_left)) >> 2);
  assign n_right = sspg_pkg::DIV_N_W'(({g_right, 2'b00} + (2*HW+2)'(g_right)) >> 2);

  logic                          dl_valid, dl_sat, dr_valid, dr_sat;
  logic [sspg_pkg::DIV_Q_W-1:0]  dl_quot, dr_quot;
  logic [SW-1:0]                 dl_side, dr_side;

  sspg_div u_left_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (g_valid),
    .num       (n_left),
    .den       (g_den),
    .in_side   (SW'(g_volpos)),
    .out_valid (dl_valid),
    .sat       (dl_sat),
    .quot      (dl_quot),
    .out_side  (dl_side)
  );

  sspg_div u_right_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (g_valid),
    .num       (n_right),
    .den       (g_den),
    .in_side   (SW'(g_volpos)),
    .out_valid (dr_valid),
    .sat       (dr_sat),
    .quot      (dr_quot),
    .out_side  (dr_side)
  );

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dl_side[0]) begin
        left_gain  <= dl_sat ? sspg_pkg::GAIN_MAX : dl_quot;
        right_gain <= dr_sat ? sspg_pkg::GAIN_MAX : dr_quot;
      end else begin
        left_gain  <= dl_side[VW:1];
        right_gain <= dl_side[VW:1];
      end
    end
  end

  `SSPG_ASSERT(a_lanes_aligned, dl_valid == dr_valid && (!dl_valid || dl_side == dr_side), "gain dividers out of step")
  `SSPG_ASSERT(a_cos_range, c_valid |-> c_rad <= sspg_pkg::RAD2_W'({18'd65536, 14'd0}), "one minus cosine out of range")
  `SSPG_ASSERT(a_sin_range, r2_valid |-> r2_root <= RW'(32768), "half-angle sine above one")
  `SSPG_ASSERT(a_hold, (res_valid && res_stall) |-> src_stall, "source taken while result stalled")
  `SSPG_ASSERT_ALWAYS(a_reset_clear, rst |=> !res_valid, "result valid right after reset")

endmodule
